// ===== rtl/shortest_queue_dispatcher_top_macros.svh =====
// Assertion macros for the shortest-queue dispatcher.
`ifndef SHORTEST_QUEUE_DISPATCHER_TOP_MACROS_SVH
`define SHORTEST_QUEUE_DISPATCHER_TOP_MACROS_SVH

// Condition must never hold outside reset.
`define SQD_ASSERT_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define SQD_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Antecedent implies consequent in the next cycle.
`define SQD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/sqd_pkg.sv =====
// Package: sizes, field widths and controller/datapath bundles for the dispatcher.
`default_nettype none
package sqd_pkg;

   localparam int NUM_SERVERS = 4;
   localparam int QUEUE_DEPTH = 16;
   localparam int LENGTH_BITS = 6;

   localparam int SRV_BITS  = $clog2(NUM_SERVERS);
   localparam int PTR_BITS  = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS  = $clog2(QUEUE_DEPTH + 1);
   localparam int ADDR_BITS = $clog2(NUM_SERVERS * QUEUE_DEPTH);
   localparam int MEM_DEPTH = NUM_SERVERS * QUEUE_DEPTH;

   localparam int STAY_BITS  = 11;
   localparam int TOTAL_BITS = 32;
   localparam int ACC_BITS   = 16;
   localparam int SUM_BITS   = ((LENGTH_BITS > STAY_BITS) ? LENGTH_BITS : STAY_BITS) + 1;

   localparam logic [STAY_BITS-1:0] STAY_MAX = '1;

   typedef struct packed {
      logic capture;
      logic arrive;
      logic srv_clear;
      logic srv_next;
      logic tick_read;
      logic tick_update;
      logic load_rsp;
   } ctrl_cmd_type;

   typedef struct packed {
      logic last_srv;
   } dp_sts_type;

endpackage
`default_nettype wire

// ===== rtl/sqd_ifs.sv =====
// Handshake channel interfaces for dispatcher requests and responses.
`default_nettype none
interface sqd_req_if
   import sqd_pkg::*;
   ();
   logic                   valid;
   logic                   ready;
   logic                   func;
   logic [LENGTH_BITS-1:0] job_length;

   modport source (output valid, func, job_length, input ready);
   modport sink   (input valid, func, job_length, output ready);
endinterface

interface sqd_rsp_if
   import sqd_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic [SRV_BITS-1:0]   assigned_server;
   logic [STAY_BITS-1:0]  stay_time;
   logic                  dropped;
   logic                  all_idle;
   logic [TOTAL_BITS-1:0] total_stay;
   logic [ACC_BITS-1:0]   jobs_accepted;

   modport source (output valid, assigned_server, stay_time, dropped, all_idle,
                   total_stay, jobs_accepted, input ready);
   modport sink   (input valid, assigned_server, stay_time, dropped, all_idle,
                   total_stay, jobs_accepted, output ready);
endinterface
`default_nettype wire

// ===== rtl/shortest_queue_dispatcher_top.sv =====
// Top level of the join-shortest-queue dispatcher.
//
//   channel  direction  item carries
//   req_ch   in         func, job_length
//   rsp_ch   out        assigned_server, stay_time, dropped, all_idle,
//                       total_stay, jobs_accepted
//
// An arrival passes the ARRIVE and FINISH states on its way to the response
// register, a tick a TICK_RD and a TICK_UPD state per server and then FINISH:
// each server's tick reads the next head length from the FIFO memory and then
// updates. FINISH waits while the response register is full and not being
// emptied; the controller then returns to idle before the next item is taken.
// One item is in work at a time; req_ch.ready is high only while idle.
// The response register holds a finished item while the next is taken in.
// Reset is synchronous and clears all server state, totals and rsp_ch.valid.
`default_nettype none
`include "shortest_queue_dispatcher_top_macros.svh"
module shortest_queue_dispatcher_top
   import sqd_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   sqd_req_if.sink   req_ch,
   sqd_rsp_if.source rsp_ch
);

   ctrl_cmd_type cmd;
   dp_sts_type   sts;

   sqd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_func  (req_ch.func),
      .req_ready (req_ch.ready),
      .rsp_ready (rsp_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .sts       (sts),
      .cmd       (cmd)
   );

   sqd_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .req_job_length      (req_ch.job_length),
      .rsp_assigned_server (rsp_ch.assigned_server),
      .rsp_stay_time       (rsp_ch.stay_time),
      .rsp_dropped         (rsp_ch.dropped),
      .rsp_all_idle        (rsp_ch.all_idle),
      .rsp_total_stay      (rsp_ch.total_stay),
      .rsp_jobs_accepted   (rsp_ch.jobs_accepted)
   );

   `SQD_ASSERT_NEXT(a_busy_after_accept, req_ch.valid && req_ch.ready, !req_ch.ready,
                    "ready high right after an item was taken")
   `SQD_ASSERT_SAME(a_drop_no_stay, rsp_ch.valid && rsp_ch.dropped, rsp_ch.stay_time == '0,
                    "dropped item carries a stay time")
   `SQD_ASSERT_NEVER(a_drop_not_idle, rsp_ch.valid && rsp_ch.dropped && rsp_ch.all_idle,
                     "full queue reported alongside all idle")

endmodule
`default_nettype wire

// ===== rtl/sqd_ctrl.sv =====
// Dispatcher controller: sequences arrivals, per-server ticks and the response register.
`default_nettype none
module sqd_ctrl
   import sqd_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   input  wire logic         req_func,
   output logic              req_ready,
   input  wire logic         rsp_ready,
   output logic              rsp_valid,
   input  wire dp_sts_type   sts,
   output ctrl_cmd_type      cmd
);

   typedef enum logic [4:0] {
      ST_IDLE     = 5'b00001,
      ST_ARRIVE   = 5'b00010,
      ST_TICK_RD  = 5'b00100,
      ST_TICK_UPD = 5'b01000,
      ST_FINISH   = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture   = 1'b1;
               cmd.srv_clear = 1'b1;
               state_in      = req_func ? ST_ARRIVE : ST_TICK_RD;
            end
         end
         ST_ARRIVE: begin
            cmd.arrive = 1'b1;
            state_in   = ST_FINISH;
         end
         ST_TICK_RD: begin
            cmd.tick_read = 1'b1;
            state_in      = ST_TICK_UPD;
         end
         ST_TICK_UPD: begin
            cmd.tick_update = 1'b1;
            if (sts.last_srv) begin
               state_in = ST_FINISH;
            end else begin
               cmd.srv_next = 1'b1;
               state_in     = ST_TICK_RD;
            end
         end
         ST_FINISH: begin
            // wait until the response register is free or being emptied
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/sqd_datapath.sv =====
// Dispatcher datapath: server state, job-length FIFO memory, totals and response register.
`default_nettype none
module sqd_datapath
   import sqd_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire ctrl_cmd_type           cmd,
   output dp_sts_type                  sts,
   input  wire logic [LENGTH_BITS-1:0] req_job_length,
   output logic [SRV_BITS-1:0]         rsp_assigned_server,
   output logic [STAY_BITS-1:0]        rsp_stay_time,
   output logic                        rsp_dropped,
   output logic                        rsp_all_idle,
   output logic [TOTAL_BITS-1:0]       rsp_total_stay,
   output logic [ACC_BITS-1:0]         rsp_jobs_accepted
);

   // per-server state
   logic [STAY_BITS-1:0]   backlog_ff [NUM_SERVERS];
   logic [STAY_BITS-1:0]   backlog_in [NUM_SERVERS];
   logic [LENGTH_BITS-1:0] cur_ff     [NUM_SERVERS];
   logic [LENGTH_BITS-1:0] cur_in     [NUM_SERVERS];
   logic [CNT_BITS-1:0]    cnt_ff     [NUM_SERVERS];
   logic [CNT_BITS-1:0]    cnt_in     [NUM_SERVERS];
   logic [PTR_BITS-1:0]    head_ff    [NUM_SERVERS];
   logic [PTR_BITS-1:0]    head_in    [NUM_SERVERS];

   logic [TOTAL_BITS-1:0]  sum_ff, sum_in;
   logic [ACC_BITS-1:0]    acc_ff, acc_in;

   logic [SRV_BITS-1:0]    srv_ff, srv_in;
   logic [LENGTH_BITS-1:0] len_ff, len_in;

   logic [SRV_BITS-1:0]    res_srv_ff, res_srv_in;
   logic [STAY_BITS-1:0]   res_stay_ff, res_stay_in;
   logic                   res_drop_ff, res_drop_in;

   logic [LENGTH_BITS-1:0] mem [MEM_DEPTH];
   logic [LENGTH_BITS-1:0] rd_data_ff;

   logic [SRV_BITS-1:0]    best;
   logic [CNT_BITS-1:0]    best_cnt;
   logic [SRV_BITS-1:0]    sel;
   logic [STAY_BITS-1:0]   sel_backlog;
   logic [LENGTH_BITS-1:0] sel_cur;
   logic [CNT_BITS-1:0]    sel_cnt;
   logic [PTR_BITS-1:0]    sel_head;
   logic [PTR_BITS-1:0]    head_next;
   logic [PTR_BITS:0]      tail_sum;
   logic [PTR_BITS-1:0]    tail;
   logic [SUM_BITS-1:0]    stay_sum;
   logic [STAY_BITS-1:0]   stay;
   logic [TOTAL_BITS:0]    total_sum;
   logic                   full;
   logic                   finished;
   logic                   wr_en;
   logic [ADDR_BITS-1:0]   wr_addr;
   logic [ADDR_BITS-1:0]   rd_addr;
   logic                   idle;

   function automatic logic [ADDR_BITS-1:0] mem_addr(input logic [SRV_BITS-1:0] s,
                                                     input logic [PTR_BITS-1:0] p);
      mem_addr = ADDR_BITS'(s) * ADDR_BITS'(QUEUE_DEPTH) + ADDR_BITS'(p);
   endfunction

   // shortest queue, lowest index on ties
   always_comb begin
      best     = '0;
      best_cnt = cnt_ff[0];
      for (int s = 1; s < NUM_SERVERS; s++) begin
         if (cnt_ff[s] < best_cnt) begin
            best     = SRV_BITS'(s);
            best_cnt = cnt_ff[s];
         end
      end
   end

   assign sel         = cmd.arrive ? best : srv_ff;
   assign sel_backlog = backlog_ff[sel];
   assign sel_cur     = cur_ff[sel];
   assign sel_cnt     = cnt_ff[sel];
   assign sel_head    = head_ff[sel];

   assign head_next = (sel_head == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : sel_head + 1'b1;
   assign tail_sum  = (PTR_BITS + 1)'(sel_head) + (PTR_BITS + 1)'(sel_cnt);
   assign tail      = (tail_sum >= (PTR_BITS + 1)'(QUEUE_DEPTH)) ?
                      PTR_BITS'(tail_sum - (PTR_BITS + 1)'(QUEUE_DEPTH)) :
                      PTR_BITS'(tail_sum);
   assign full      = (sel_cnt >= CNT_BITS'(QUEUE_DEPTH));
   assign stay_sum  = SUM_BITS'(sel_backlog) + SUM_BITS'(len_ff);
   assign stay      = (stay_sum > SUM_BITS'(STAY_MAX)) ? STAY_MAX : STAY_BITS'(stay_sum);
   assign total_sum = (TOTAL_BITS + 1)'(sum_ff) + (TOTAL_BITS + 1)'(stay);
   // the head is done when its last tick runs, or at once for a zero-length job
   assign finished  = (sel_cur == LENGTH_BITS'(1)) ||
                      ((sel_cur == '0) && (sel_cnt != '0));
   assign wr_addr   = mem_addr(sel, tail);
   assign rd_addr   = mem_addr(sel, head_next);

   assign sts.last_srv = (srv_ff == SRV_BITS'(NUM_SERVERS - 1));

   always_comb begin
      backlog_in  = backlog_ff;
      cur_in      = cur_ff;
      cnt_in      = cnt_ff;
      head_in     = head_ff;
      sum_in      = sum_ff;
      acc_in      = acc_ff;
      srv_in      = srv_ff;
      len_in      = len_ff;
      res_srv_in  = res_srv_ff;
      res_stay_in = res_stay_ff;
      res_drop_in = res_drop_ff;
      wr_en       = 1'b0;

      if (cmd.capture) begin
         len_in      = req_job_length;
         res_srv_in  = '0;
         res_stay_in = '0;
         res_drop_in = 1'b0;
      end
      if (cmd.srv_clear) begin
         srv_in = '0;
      end else if (cmd.srv_next) begin
         srv_in = srv_ff + 1'b1;
      end

      if (cmd.arrive) begin
         res_srv_in = best;
         if (full) begin
            res_drop_in = 1'b1;
         end else begin
            wr_en = 1'b1;
            if (sel_cnt == '0) begin
               cur_in[sel] = len_ff;
            end
            cnt_in[sel]     = sel_cnt + 1'b1;
            backlog_in[sel] = stay;
            res_stay_in     = stay;
            sum_in          = total_sum[TOTAL_BITS] ? '1 : total_sum[TOTAL_BITS-1:0];
            if (acc_ff != '1) begin
               acc_in = acc_ff + 1'b1;
            end
         end
      end

      if (cmd.tick_update) begin
         if (sel_backlog != '0) begin
            backlog_in[sel] = sel_backlog - 1'b1;
         end
         if (sel_cur != '0) begin
            cur_in[sel] = sel_cur - 1'b1;
         end
         if (finished && (sel_cnt != '0)) begin
            head_in[sel] = head_next;
            cnt_in[sel]  = sel_cnt - 1'b1;
            cur_in[sel]  = (sel_cnt != CNT_BITS'(1)) ? rd_data_ff : '0;
         end
      end
   end

   always_comb begin
      idle = 1'b1;
      for (int s = 0; s < NUM_SERVERS; s++) begin
         if ((backlog_ff[s] != '0) || (cnt_ff[s] != '0)) begin
            idle = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= len_ff;
      end
      if (cmd.tick_read) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NUM_SERVERS; s++) begin
            backlog_ff[s] <= '0;
            cur_ff[s]     <= '0;
            cnt_ff[s]     <= '0;
            head_ff[s]    <= '0;
         end
         sum_ff <= '0;
         acc_ff <= '0;
         srv_ff <= '0;
      end else begin
         backlog_ff <= backlog_in;
         cur_ff     <= cur_in;
         cnt_ff     <= cnt_in;
         head_ff    <= head_in;
         sum_ff     <= sum_in;
         acc_ff     <= acc_in;
         srv_ff     <= srv_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff      <= len_in;
      res_srv_ff  <= res_srv_in;
      res_stay_ff <= res_stay_in;
      res_drop_ff <= res_drop_in;
      if (cmd.load_rsp) begin
         rsp_assigned_server <= res_srv_ff;
         rsp_stay_time       <= res_stay_ff;
         rsp_dropped         <= res_drop_ff;
         rsp_all_idle        <= idle;
         rsp_total_stay      <= sum_ff;
         rsp_jobs_accepted   <= acc_ff;
      end
   end

endmodule
`default_nettype wire
